[rtl/u16to32_pkg.sv]
// Package for the UTF-16 to UTF-32 converter: code constants, the result
// record type and the byte-swap helper.
// No dependencies.
package u16to32_pkg;

	localparam logic [5:0]  LeadTag   = 6'b110110;  // 0xd800 under mask 0xfc00
	localparam logic [5:0]  TrailTag  = 6'b110111;  // 0xdc00 under mask 0xfc00
	localparam logic [31:0] SuppBase  = 32'h0001_0000;
	localparam logic [31:0] ReplChar  = 32'h0000_fffd;
	localparam logic [31:0] MarkChar  = 32'h0000_feff;

	typedef struct packed {
		logic [31:0] word;
		logic        replaced;
		logic        run_end;
		logic        doc_end;
	} result_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

[rtl/utf16_to_utf32_converter.sv]
// UTF-16 to UTF-32 converter, top level.
// Depends on u16to32_pkg.
//
// Usage:
// Code units arrive on the input channel (in_valid, in_stall, code_unit,
// final_unit); 32-bit words leave on the output channel (out_valid,
// out_stall, out_word, replaced, run_end, doc_end). A transfer happens at
// a rising edge where valid is high and stall is low. The byte-order
// register is written through cfg_valid/cfg_ready/big_endian; the user
// must write it only while idle, the block itself does not enforce it.
// Each unit is held in one input register; short logic decodes it
// against the held lead surrogate and pushes zero, one or two results
// into a two-entry result buffer. The block takes one unit per cycle
// while each unit yields one word and the receiver does not stall; a unit
// that yields two words (the byte-order mark or a replaced lead followed
// by the unit itself) takes extra output port time, as the single output
// port sends one word at a time. When the receiver stalls, the buffer fills
// and in_stall rises; nothing is lost. Reset clears the buffer, the input
// register, the held lead, the mark flag and sets little-endian output.
module utf16_to_utf32_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        final_unit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_word,
	output logic        replaced,
	output logic        run_end,
	output logic        doc_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        big_endian
);
	import u16to32_pkg::*;

	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        fin_s1;

	logic        big_endian_q;
	logic        lead_pending_q;
	logic [9:0]  lead_bits_q;
	logic        mark_sent_q;

	result_t     buf_q [2];
	logic        rd_ptr_q;
	logic        wr_ptr_q;
	logic [1:0]  count_q;

	logic        is_lead, is_trail, pair;
	logic        pre_valid, main_valid;
	logic [1:0]  n_res;
	result_t     pre_res, main_res, r0, r1;
	logic [31:0] pre_cp, main_cp;
	logic        main_repl;
	logic        pop, room, advance, accept;

	assign cfg_ready = 1'b1;

	// Decode of the unit held in the input register.
	always_comb begin
		is_lead    = (unit_s1[15:10] == LeadTag);
		is_trail   = (unit_s1[15:10] == TrailTag);
		pair       = lead_pending_q && is_trail;
		pre_valid  = !mark_sent_q || (lead_pending_q && !is_trail);
		main_valid = pair || !is_lead || fin_s1;
		pre_cp     = mark_sent_q ? ReplChar : MarkChar;
		if (pair) begin
			main_cp   = SuppBase + {12'd0, lead_bits_q, unit_s1[9:0]};
			main_repl = 1'b0;
		end else if (is_lead || is_trail) begin
			main_cp   = ReplChar;
			main_repl = 1'b1;
		end else begin
			main_cp   = {16'd0, unit_s1};
			main_repl = 1'b0;
		end
		pre_res.word      = big_endian_q ? swap32(pre_cp) : pre_cp;
		pre_res.replaced  = mark_sent_q;
		pre_res.run_end   = !main_valid;
		pre_res.doc_end   = fin_s1 && !main_valid;
		main_res.word     = big_endian_q ? swap32(main_cp) : main_cp;
		main_res.replaced = main_repl;
		main_res.run_end  = 1'b1;
		main_res.doc_end  = fin_s1;
		r0    = pre_valid ? pre_res : main_res;
		r1    = main_res;
		n_res = {1'b0, pre_valid} + {1'b0, main_valid};
	end

	assign pop = out_valid && !out_stall;

	// Buffer space, counting the entry that leaves this cycle.
	always_comb begin
		case (n_res)
			2'd0:    room = 1'b1;
			2'd1:    room = (count_q != 2'd2) || pop;
			default: room = (count_q == 2'd0) || ((count_q == 2'd1) && pop);
		endcase
	end

	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unit_s1 <= code_unit;
			fin_s1  <= final_unit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			big_endian_q <= big_endian;
		end
	end

	// Document state moves when the held unit is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			lead_bits_q    <= '0;
			mark_sent_q    <= 1'b0;
		end else if (advance) begin
			if (fin_s1) begin
				lead_pending_q <= 1'b0;
				lead_bits_q    <= '0;
				mark_sent_q    <= 1'b0;
			end else begin
				lead_pending_q <= is_lead;
				lead_bits_q    <= is_lead ? unit_s1[9:0] : 10'd0;
				mark_sent_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (n_res != 2'd0)) begin
			buf_q[wr_ptr_q] <= r0;
		end
		if (advance && (n_res == 2'd2)) begin
			buf_q[~wr_ptr_q] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (advance) begin
				wr_ptr_q <= wr_ptr_q ^ n_res[0];
				count_q  <= count_q + n_res - {1'b0, pop};
			end else begin
				count_q  <= count_q - {1'b0, pop};
			end
		end
	end

	assign out_valid = (count_q != 2'd0);
	assign out_word  = buf_q[rd_ptr_q].word;
	assign replaced  = buf_q[rd_ptr_q].replaced;
	assign run_end   = buf_q[rd_ptr_q].run_end;
	assign doc_end   = buf_q[rd_ptr_q].doc_end;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer count out of range");

	a_two_fit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (n_res == 2'd2) |-> (count_q == 2'd0) || ((count_q == 2'd1) && pop))
		else $error("two results pushed without room");

	a_lead_after_mark: assert property (@(posedge clk) disable iff (!arst_n)
		lead_pending_q |-> mark_sent_q)
		else $error("lead held before the mark was sent");

	a_doc_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && fin_s1 |=> !lead_pending_q && !mark_sent_q)
		else $error("document state not cleared after the final unit");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && (n_res != 2'd0))
		else $error("input stalled with nothing to push");

endmodule

[test/u16to32_word_checker.sv]
`timescale 1ns / 100ps
// Checker for the UTF-16 to UTF-32 converter: tracks the byte-order register,
// predicts the 32-bit words for every accepted code unit and compares them
// with the output transfers. Depends on u16to32_pkg.
module u16to32_word_checker
	import u16to32_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        final_unit,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] out_word,
	input  logic        replaced,
	input  logic        run_end,
	input  logic        doc_end,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        big_endian,
	output int          mismatches,
	output int          awaited
);

	result_t     words_due[$];
	logic        order_be;
	logic        lead_held;
	logic [9:0]  lead_low;
	logic        mark_done;

	function automatic result_t make_word(input logic [31:0] cp, input logic sub);
		result_t r;
		r.word     = order_be ? {cp[7:0], cp[15:8], cp[23:16], cp[31:24]} : cp;
		r.replaced = sub;
		r.run_end  = 1'b0;
		r.doc_end  = 1'b0;
		return r;
	endfunction

	// Builds the zero, one or two words that one code unit releases.
	function automatic void decode_unit(input logic [15:0] unit, input logic fin);
		result_t    made[2];
		int         n;
		logic [5:0] tag;
		logic       paired;
		n = 0;
		tag = unit[15:10];
		paired = 1'b0;
		if (!mark_done) begin
			made[n] = make_word(MarkChar, 1'b0);
			n++;
			mark_done = 1'b1;
		end
		if (lead_held) begin
			if (tag == TrailTag) begin
				made[n] = make_word(SuppBase + {12'd0, lead_low, unit[9:0]}, 1'b0);
				paired = 1'b1;
			end else begin
				made[n] = make_word(ReplChar, 1'b1);
			end
			n++;
			lead_held = 1'b0;
			lead_low = '0;
		end
		if (!paired) begin
			if (tag == LeadTag) begin
				// A lead on the last unit of a document cannot wait for its trail.
				if (fin) begin
					made[n] = make_word(ReplChar, 1'b1);
					n++;
				end else begin
					lead_held = 1'b1;
					lead_low = unit[9:0];
				end
			end else if (tag == TrailTag) begin
				made[n] = make_word(ReplChar, 1'b1);
				n++;
			end else begin
				made[n] = make_word({16'd0, unit}, 1'b0);
				n++;
			end
		end
		if (n > 0) begin
			made[n - 1].run_end = 1'b1;
			made[n - 1].doc_end = fin;
		end
		for (int i = 0; i < n; i++)
			words_due.push_back(made[i]);
		if (fin) begin
			lead_held = 1'b0;
			lead_low = '0;
			mark_done = 1'b0;
		end
	endfunction

	function automatic void check_word();
		result_t want;
		if (words_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected word %h replaced %b run_end %b doc_end %b",
					$realtime, out_word, replaced, run_end, doc_end);
		end else begin
			want = words_due.pop_front();
			if (want.word !== out_word || want.replaced !== replaced ||
					want.run_end !== run_end || want.doc_end !== doc_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected %h %b %b %b, got %h %b %b %b (word replaced run_end doc_end)",
						$realtime, want.word, want.replaced, want.run_end, want.doc_end,
						out_word, replaced, run_end, doc_end);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_due.delete();
			order_be = 1'b0;
			lead_held = 1'b0;
			lead_low = '0;
			mark_done = 1'b0;
			awaited = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				order_be = big_endian;
			if (in_valid && !in_stall)
				decode_unit(code_unit, final_unit);
			if (out_valid && !out_stall)
				check_word();
			awaited = words_due.size();
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the converter testbench: clock, reset, code unit documents, receiver
// stalls and the byte-order writes. Depends on utf16_to_utf32_converter and
// u16to32_word_checker, which predicts and compares.
module testbench;

	localparam int QUIET      = 8;
	localparam int LONG_HOLD  = 80;
	localparam int PHASE_SIZE = 350;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] code_unit;
	logic        final_unit;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] out_word;
	logic        replaced;
	logic        run_end;
	logic        doc_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        big_endian;
	int          mismatches;
	int          awaited;
	int          gap_pct;
	int          stall_pct;
	bit          long_hold;

	utf16_to_utf32_converter uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.replaced   (replaced),
		.run_end    (run_end),
		.doc_end    (doc_end),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.big_endian (big_endian)
	);

	u16to32_word_checker word_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.replaced   (replaced),
		.run_end    (run_end),
		.doc_end    (doc_end),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.big_endian (big_endian),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_unit(input logic [15:0] unit, input logic fin);
		code_unit <= unit;
		final_unit <= fin;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Stops sending units, then waits until every predicted word has left
	// and the pipeline is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (QUIET) @(posedge clk);
	endtask

	task automatic set_order(input logic be);
		settle();
		cfg_valid <= 1'b1;
		big_endian <= be;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] plain_unit();
		logic [15:0] u;
		case ($urandom_range(0, 7))
			0: u = 16'h0000;
			1: u = 16'hffff;
			2: u = 16'hd7ff;
			3: u = 16'he000;
			default: begin
				u = 16'($urandom);
				while (u[15:11] == 5'b11011) u = 16'($urandom);
			end
		endcase
		return u;
	endfunction

	// Mostly well-formed text with pairs, salted with lone trails and leads.
	// With cut_tail the last document may stop short of its final unit, so
	// the next phase continues it under the new byte order.
	task automatic run_docs(input int budget, input bit cut_tail);
		logic [15:0] doc[$];
		logic [15:0] r;
		int          sent;
		int          len;
		int          keep;
		int          pick;
		sent = 0;
		while (sent < budget) begin
			doc.delete();
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			while (doc.size() < len) begin
				pick = $urandom_range(0, 99);
				r = 16'($urandom);
				if (pick < 55) begin
					doc.push_back(plain_unit());
				end else if (pick < 82) begin
					doc.push_back({u16to32_pkg::LeadTag, r[9:0]});
					r = 16'($urandom);
					doc.push_back({u16to32_pkg::TrailTag, r[9:0]});
				end else if (pick < 91) begin
					doc.push_back({u16to32_pkg::TrailTag, r[9:0]});
				end else begin
					doc.push_back({u16to32_pkg::LeadTag, r[9:0]});
				end
			end
			keep = doc.size();
			if (cut_tail && sent + keep >= budget && keep > 1 && $urandom_range(0, 1) == 1)
				keep = $urandom_range(1, keep - 1);
			for (int i = 0; i < keep; i++)
				send_unit(doc[i], i == doc.size() - 1);
			sent += keep;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		code_unit <= '0;
		final_unit <= 1'b0;
		cfg_valid <= 1'b0;
		big_endian <= 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_order(1'b0);
		gap_pct = 15;
		stall_pct = 15;
		send_unit(16'h0000, 1'b1);
		send_unit(16'hffff, 1'b0);
		send_unit(16'hd800, 1'b0);   // smallest pair
		send_unit(16'hdc00, 1'b0);
		send_unit(16'hdbff, 1'b0);   // largest pair
		send_unit(16'hdfff, 1'b0);
		send_unit(16'hd7ff, 1'b0);
		send_unit(16'he000, 1'b0);
		send_unit(16'hdc00, 1'b0);   // lone trail
		send_unit(16'hd800, 1'b0);   // lead followed by a plain unit
		send_unit(16'h0041, 1'b0);
		send_unit(16'hdbff, 1'b0);   // lead followed by another lead
		send_unit(16'hd800, 1'b0);
		send_unit(16'hdfff, 1'b0);
		send_unit(16'hd800, 1'b1);   // lead on the last unit
		send_unit(16'hd801, 1'b0);
		send_unit(16'h0062, 1'b1);
		send_unit(16'hd834, 1'b0);
		send_unit(16'hdd1e, 1'b1);
		send_unit(16'hdabc, 1'b1);
		// A lead is held across the byte-order change.
		send_unit(16'hd83d, 1'b0);

		set_order(1'b1);
		gap_pct = 20;
		stall_pct = 20;
		run_docs(PHASE_SIZE, 1'b1);

		set_order(1'b0);
		gap_pct = 0;
		stall_pct = 30;
		long_hold = 1'b1;
		run_docs(PHASE_SIZE, 1'b1);

		set_order(1'b1);
		gap_pct = 40;
		stall_pct = 0;
		run_docs(PHASE_SIZE, 1'b1);

		set_order(1'b0);
		gap_pct = 10;
		stall_pct = 50;
		run_docs(PHASE_SIZE, 1'b1);

		set_order(1'b1);
		gap_pct = 0;
		stall_pct = 0;
		run_docs(PHASE_SIZE, 1'b0);

		settle();
		if (mismatches == 0 && awaited == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
